/* src/nnt_pkg.sv */
`default_nettype none

package nnt_pkg;

	// Fixed field geometry of a beat
	localparam int COORD_BITS = 16;
	localparam int DIMS = 4;
	localparam int OUT_DIMS = 2;
	localparam int ANS_BITS = 32;
	localparam int IDX_W = 6;
	localparam int CFG_W = 7;
	localparam int CFG_IDX_W = 1;
	localparam int ENTRIES_W = 7;
	localparam int DIMS_W = 3;
	localparam int DIFF_W = COORD_BITS;
	localparam int SQ_W = 2 * COORD_BITS;
	localparam int DIST_W = SQ_W + $clog2(DIMS);
	localparam int POINT_W = DIMS * COORD_BITS;
	localparam int ANSWER_W = OUT_DIMS * ANS_BITS;

	// Default table depth
	localparam int MAX_ENTRIES_DEF = 64;

	// Register reset values
	localparam logic [ENTRIES_W-1:0] ENTRIES_RST = 7'd1;
	localparam logic [DIMS_W-1:0] DIMS_RST = 3'd4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIMS = 1'b1;

	// Command and result codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;
	localparam logic KIND_ACK = 1'b0;
	localparam logic KIND_ANSWER = 1'b1;

	typedef struct packed {
		logic opcode;
		logic [IDX_W-1:0] entry_index;
		logic signed [COORD_BITS-1:0] coord_0;
		logic signed [COORD_BITS-1:0] coord_1;
		logic signed [COORD_BITS-1:0] coord_2;
		logic signed [COORD_BITS-1:0] coord_3;
		logic signed [ANS_BITS-1:0] value_0;
		logic signed [ANS_BITS-1:0] value_1;
	} cmd_t;

	typedef struct packed {
		logic kind;
		logic signed [ANS_BITS-1:0] answer_0;
		logic signed [ANS_BITS-1:0] answer_1;
		logic [IDX_W-1:0] nearest_index;
		logic [DIST_W-1:0] distance_sq;
	} result_t;

	// Control that travels with each scanned entry
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} scan_tag_t;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_DRAIN = 4'b0100,
		S_FETCH = 4'b1000
	} state_t;

endpackage

`default_nettype wire

/* src/nnt_table.sv */
`default_nettype none

module nnt_table #(
	parameter int MAX_ENTRIES = nnt_pkg::MAX_ENTRIES_DEF,
	parameter int AW = 6
) (
	input  wire logic                         clk,
	input  wire logic                         wr_en,
	input  wire logic [AW-1:0]                wr_addr,
	input  wire logic [nnt_pkg::POINT_W-1:0]  wr_point,
	input  wire logic [nnt_pkg::ANSWER_W-1:0] wr_answer,
	input  wire logic                         pt_rd_en,
	input  wire logic [AW-1:0]                pt_rd_addr,
	output logic      [nnt_pkg::POINT_W-1:0]  pt_rd_data,
	input  wire logic                         ans_rd_en,
	input  wire logic [AW-1:0]                ans_rd_addr,
	output logic      [nnt_pkg::ANSWER_W-1:0] ans_rd_data
);

	logic [nnt_pkg::POINT_W-1:0] point_mem [MAX_ENTRIES];
	logic [nnt_pkg::ANSWER_W-1:0] answer_mem [MAX_ENTRIES];

	// Point store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			point_mem[wr_addr] <= wr_point;
		end
		if (pt_rd_en) begin
			pt_rd_data <= point_mem[pt_rd_addr];
		end
	end

	// Answer store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			answer_mem[wr_addr] <= wr_answer;
		end
		if (ans_rd_en) begin
			ans_rd_data <= answer_mem[ans_rd_addr];
		end
	end

endmodule

`default_nettype wire

/* src/nnt_dist.sv */
`default_nettype none

module nnt_dist #(
	parameter int AW = 6
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire nnt_pkg::scan_tag_t          tag,
	input  wire logic [nnt_pkg::POINT_W-1:0] point,
	input  wire logic [nnt_pkg::POINT_W-1:0] query,
	input  wire logic [nnt_pkg::DIMS-1:0]    dmask,
	output logic                             done,
	output logic [AW-1:0]                    best_index,
	output logic [nnt_pkg::DIST_W-1:0]       best_dist
);

	localparam int CB = nnt_pkg::COORD_BITS;
	localparam int ND = nnt_pkg::DIMS;

	nnt_pkg::scan_tag_t tag_s1, tag_s2, tag_s3, tag_s4;
	logic [nnt_pkg::DIFF_W-1:0] diff_d;
	logic [nnt_pkg::DIFF_W-1:0] diff_s2 [ND];
	logic [nnt_pkg::SQ_W-1:0] sq_s3 [ND];
	logic [nnt_pkg::DIST_W-1:0] sum_d;
	logic [nnt_pkg::DIST_W-1:0] sum_s4;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] cur_idx;
	logic [nnt_pkg::DIST_W-1:0] best_d_q;
	logic [AW-1:0] best_i_q;
	logic done_q;
	logic signed [CB:0] delta [ND];
	logic [nnt_pkg::DIFF_W-1:0] absd [ND];

	// Advance the tag alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s1 <= tag;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	// Absolute coordinate differences, unused dimensions forced to zero
	always_comb begin
		for (int d = 0; d < ND; d++) begin
			delta[d] = $signed({point[d*CB+CB-1], point[d*CB +: CB]})
				- $signed({query[d*CB+CB-1], query[d*CB +: CB]});
			diff_d = delta[d][CB] ? nnt_pkg::DIFF_W'(-delta[d])
				: nnt_pkg::DIFF_W'(delta[d]);
			absd[d] = dmask[d] ? diff_d : '0;
		end
	end

	always_ff @(posedge clk) begin
		for (int d = 0; d < ND; d++) begin
			diff_s2[d] <= absd[d];
		end
	end

	// Square each difference
	always_ff @(posedge clk) begin
		for (int d = 0; d < ND; d++) begin
			sq_s3[d] <= diff_s2[d] * diff_s2[d];
		end
	end

	// Sum the squares
	always_comb begin
		sum_d = '0;
		for (int d = 0; d < ND; d++) begin
			sum_d = sum_d + nnt_pkg::DIST_W'(sq_s3[d]);
		end
	end

	always_ff @(posedge clk) begin
		sum_s4 <= sum_d;
	end

	// Keep the running minimum; a tie keeps the earlier entry
	assign cur_idx = tag_s4.first ? '0 : AW'(idx_q + 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= tag_s4.valid && tag_s4.last;
			if (tag_s4.valid) begin
				idx_q <= cur_idx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tag_s4.valid && (tag_s4.first || (sum_s4 < best_d_q))) begin
			best_d_q <= sum_s4;
			best_i_q <= cur_idx;
		end
	end

	assign done = done_q;
	assign best_index = best_i_q;
	assign best_dist = best_d_q;

endmodule

`default_nettype wire

/* src/nearest_neighbor_table_lookup.sv */
// Nearest-neighbor table lookup. Issue a command by raising start while busy is low; the
// beat is taken at that edge. A write fills one table entry at that same edge and its
// acknowledge appears on result, with done high, in the next cycle; busy stays low, so
// writes can follow each other every cycle. A query scans entries 0 to entries_in_use-1,
// one entry per cycle out of the point memory, through a four-stage distance pipeline,
// then fetches the winner's answer from the answer memory: busy stays high until the
// answer is registered (entries_in_use taken as 1 if zero, capped at MAX_ENTRIES),
// and done pulses for one cycle as busy falls. The receiver cannot hold off a result,
// so sample result whenever done is high. Write configuration only while busy is low.
// Entries that a query scans must have been written first.
`default_nettype none

module nearest_neighbor_table_lookup #(
	parameter int MAX_ENTRIES = nnt_pkg::MAX_ENTRIES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire nnt_pkg::cmd_t                 cmd,
	input  wire logic                          cfg_we,
	input  wire logic [nnt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [nnt_pkg::CFG_W-1:0]     cfg_data,
	output logic                               done,
	output nnt_pkg::result_t                   result
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	nnt_pkg::state_t state_q;
	logic [nnt_pkg::ENTRIES_W-1:0] entries_q;
	logic [nnt_pkg::DIMS_W-1:0] dims_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] n_d;
	logic [nnt_pkg::POINT_W-1:0] query_q;
	logic [nnt_pkg::DIMS-1:0] dmask_q;
	logic [nnt_pkg::DIMS-1:0] dmask_d;
	logic done_q;
	nnt_pkg::result_t result_q;

	logic accept;
	logic wr_accept;
	logic q_accept;
	logic wr_en;
	logic [nnt_pkg::POINT_W-1:0] cmd_point;
	nnt_pkg::scan_tag_t scan_tag;
	logic scan_last;
	logic [nnt_pkg::POINT_W-1:0] pt_rd_data;
	logic [nnt_pkg::ANSWER_W-1:0] ans_rd_data;
	logic ans_rd_en;
	logic dist_done;
	logic [AW-1:0] best_index;
	logic [nnt_pkg::DIST_W-1:0] best_dist;

	assign busy = (state_q != nnt_pkg::S_IDLE);
	assign accept = start && !busy;
	assign wr_accept = accept && (cmd.opcode == nnt_pkg::OP_WRITE);
	assign q_accept = accept && (cmd.opcode == nnt_pkg::OP_QUERY);
	assign wr_en = wr_accept && (32'(cmd.entry_index) < MAX_ENTRIES);
	assign cmd_point = {cmd.coord_3, cmd.coord_2, cmd.coord_1, cmd.coord_0};

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= nnt_pkg::ENTRIES_RST;
			dims_q <= nnt_pkg::DIMS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				nnt_pkg::CFG_ENTRIES: entries_q <= cfg_data[nnt_pkg::ENTRIES_W-1:0];
				nnt_pkg::CFG_DIMS: dims_q <= cfg_data[nnt_pkg::DIMS_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the scan length and build the dimension mask
	always_comb begin
		if (32'(entries_q) > MAX_ENTRIES) begin
			n_d = CNT_W'(MAX_ENTRIES);
		end else if (entries_q == '0) begin
			n_d = CNT_W'(1);
		end else begin
			n_d = CNT_W'(entries_q);
		end
		for (int d = 0; d < nnt_pkg::DIMS; d++) begin
			dmask_d[d] = (32'(dims_q) > d);
		end
	end

	// Hold the query for the whole scan
	always_ff @(posedge clk) begin
		if (q_accept) begin
			query_q <= cmd_point;
			dmask_q <= dmask_d;
			n_q <= n_d;
		end
	end

	assign scan_last = (cnt_q == CNT_W'(n_q - 1'b1));
	assign scan_tag.valid = (state_q == nnt_pkg::S_SCAN);
	assign scan_tag.first = (cnt_q == '0);
	assign scan_tag.last = scan_last;
	assign ans_rd_en = (state_q == nnt_pkg::S_DRAIN) && dist_done;

	// Sequencer: scan, drain the pipeline, fetch the answer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nnt_pkg::S_IDLE;
			cnt_q <= '0;
		end else begin
			case (state_q)
				nnt_pkg::S_IDLE: begin
					cnt_q <= '0;
					if (q_accept) begin
						state_q <= nnt_pkg::S_SCAN;
					end
				end
				nnt_pkg::S_SCAN: begin
					cnt_q <= CNT_W'(cnt_q + 1'b1);
					if (scan_last) begin
						state_q <= nnt_pkg::S_DRAIN;
					end
				end
				nnt_pkg::S_DRAIN: begin
					if (dist_done) begin
						state_q <= nnt_pkg::S_FETCH;
					end
				end
				nnt_pkg::S_FETCH: begin
					state_q <= nnt_pkg::S_IDLE;
				end
				default: begin
					state_q <= nnt_pkg::S_IDLE;
				end
			endcase
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= wr_accept || (state_q == nnt_pkg::S_FETCH);
		end
	end

	// Result beat
	always_ff @(posedge clk) begin
		if (wr_accept) begin
			result_q.kind <= nnt_pkg::KIND_ACK;
			result_q.answer_0 <= '0;
			result_q.answer_1 <= '0;
			result_q.nearest_index <= cmd.entry_index;
			result_q.distance_sq <= '0;
		end else if (state_q == nnt_pkg::S_FETCH) begin
			result_q.kind <= nnt_pkg::KIND_ANSWER;
			result_q.answer_0 <= ans_rd_data[0 +: nnt_pkg::ANS_BITS];
			result_q.answer_1 <= ans_rd_data[nnt_pkg::ANS_BITS +: nnt_pkg::ANS_BITS];
			result_q.nearest_index <= nnt_pkg::IDX_W'(best_index);
			result_q.distance_sq <= best_dist;
		end
	end

	assign done = done_q;
	assign result = result_q;

	nnt_table #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.AW(AW)
	) u_table (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(AW'(cmd.entry_index)),
		.wr_point(cmd_point),
		.wr_answer({cmd.value_1, cmd.value_0}),
		.pt_rd_en(scan_tag.valid),
		.pt_rd_addr(AW'(cnt_q)),
		.pt_rd_data(pt_rd_data),
		.ans_rd_en(ans_rd_en),
		.ans_rd_addr(best_index),
		.ans_rd_data(ans_rd_data)
	);

	nnt_dist #(
		.AW(AW)
	) u_dist (
		.clk(clk),
		.arst_n(arst_n),
		.tag(scan_tag),
		.point(pt_rd_data),
		.query(query_q),
		.dmask(dmask_q),
		.done(dist_done),
		.best_index(best_index),
		.best_dist(best_dist)
	);

`ifndef SYNTH
	// A query holds the block busy on the next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_accept |=> busy)
		else $error("query accepted but block not busy");

	// The last distance arrives only while draining
	a_done_drain: assert property (@(posedge clk) disable iff (!arst_n)
		dist_done |-> (state_q == nnt_pkg::S_DRAIN))
		else $error("scan finished outside drain");

	// A write is acknowledged on the next cycle
	a_write_ack: assert property (@(posedge clk) disable iff (!arst_n)
		wr_accept |=> (done && (result.kind == nnt_pkg::KIND_ACK)))
		else $error("write not acknowledged");
`endif

endmodule

`default_nettype wire
